// ===== rtl/link_success_window_top_macros.svh =====
// Assertion macros for the link success window block.
`ifndef LINK_SUCCESS_WINDOW_TOP_MACROS_SVH
`define LINK_SUCCESS_WINDOW_TOP_MACROS_SVH

// Same-cycle implication.
`define LNKSW_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define LNKSW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/lnksw_pkg.sv =====
`default_nettype none
package lnksw_pkg;

  localparam int WINDOW_SLOTS_DEF = 16;
  localparam int PERIOD_W         = 31;
  localparam int TIME_W           = 32;
  localparam int TOTAL_W          = 16;
  localparam int PCT_W            = 7;
  localparam int PERCENT_SCALE    = 100;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(20000);
  localparam logic [TOTAL_W-1:0]  TOTAL_MAX    = {TOTAL_W{1'b1}};

  localparam logic ACT_TIME  = 1'b0;
  localparam logic ACT_TELEM = 1'b1;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage
`default_nettype wire

// ===== rtl/lnksw_if.sv =====
`default_nettype none
interface lnksw_in_if;
  logic                          valid;
  logic                          ready;
  logic                          action;
  logic [lnksw_pkg::TIME_W-1:0]  now_ms;

  modport source (output valid, output action, output now_ms, input ready);
  modport sink   (input valid, input action, input now_ms, output ready);
endinterface

interface lnksw_out_if #(
  parameter int FILL_W = 5
);
  logic                          valid;
  logic                          ready;
  logic [lnksw_pkg::TOTAL_W-1:0] total_received;
  logic [FILL_W-1:0]             slots_filled;
  logic [lnksw_pkg::PCT_W-1:0]   success_percent;

  modport source (output valid, output total_received, output slots_filled,
                  output success_percent, input ready);
  modport sink   (input valid, input total_received, input slots_filled,
                  input success_percent, output ready);
endinterface

interface lnksw_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [lnksw_pkg::PERIOD_W-1:0] slot_period_ms;

  modport source (output valid, output slot_period_ms, input ready);
  modport sink   (input valid, input slot_period_ms, output ready);
endinterface
`default_nettype wire

// ===== rtl/lnksw_div.sv =====
`default_nettype none
// Restoring divider, one quotient bit per cycle. Quotient must fit PCT_W bits.
module lnksw_div #(
  parameter int FILL_W = 5
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start_i,
  input  wire logic [FILL_W+lnksw_pkg::PCT_W-1:0] dividend_i,
  input  wire logic [FILL_W-1:0]                 divisor_i,
  output lnksw_pkg::div_status_t                 status_o,
  output logic [lnksw_pkg::PCT_W-1:0]            quot_o
);

  localparam int QW = lnksw_pkg::PCT_W;
  localparam int CW = $clog2(QW);

  logic [FILL_W-1:0] rem_q, rem_d;
  logic [QW-1:0]     low_q, low_d;
  logic [QW-1:0]     quot_q, quot_d;
  logic [FILL_W-1:0] dvs_q, dvs_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [FILL_W:0]   trial;
  logic [FILL_W:0]   diff;

  assign trial = {rem_q, low_q[QW-1]};
  assign diff  = trial - {1'b0, dvs_q};

  always_comb begin
    rem_d  = rem_q;
    low_d  = low_q;
    quot_d = quot_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = dividend_i[FILL_W+QW-1:QW];
      low_d  = dividend_i[QW-1:0];
      dvs_d  = divisor_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!diff[FILL_W]) begin
        rem_d = diff[FILL_W-1:0];
      end else begin
        rem_d = trial[FILL_W-1:0];
      end
      quot_d = {quot_q[QW-2:0], ~diff[FILL_W]};
      low_d  = {low_q[QW-2:0], 1'b0};
      cnt_d  = cnt_q + 1'b1;
      if (cnt_q == CW'(QW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    low_q  <= low_d;
    quot_q <= quot_d;
    dvs_q  <= dvs_d;
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign quot_o        = quot_q;

endmodule
`default_nettype wire

// ===== rtl/link_success_window_top.sv =====
// Sequence: after an input beat the FSM runs update, a serial mark count over the
//   filled slots, divider start, divide and output load; with no slot filled the divider is skipped.
// Input beats are taken only in idle, so a new item waits until the last one is loaded
//   into the output register; a result beat may wait while the next runs.
// Reset (rst_ni low, async): marks, position, fill count, total cleared,
//   slot period back to 20000 ms; no clearing pass.
`default_nettype none
module link_success_window_top #(
  parameter int WINDOW_SLOTS = lnksw_pkg::WINDOW_SLOTS_DEF,
  parameter int FILL_W       = $clog2(WINDOW_SLOTS + 1)
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  lnksw_cfg_if.sink  cfg_i,
  lnksw_in_if.sink   in_i,
  lnksw_out_if.source out_o
);

  `include "link_success_window_top_macros.svh"

  localparam int PW  = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;
  localparam int PRW = FILL_W + lnksw_pkg::PCT_W;
  localparam logic [lnksw_pkg::PCT_W-1:0] PCT_MAX =
    lnksw_pkg::PCT_W'(lnksw_pkg::PERCENT_SCALE);

  typedef enum logic [2:0] {
    ST_IDLE, ST_UPD, ST_CNT, ST_DIVS, ST_DIVW, ST_DONE
  } state_e;

  state_e                           state_q, state_d;
  logic [lnksw_pkg::PERIOD_W-1:0]   period_q, period_d;
  logic                             act_q, act_d;
  logic [lnksw_pkg::TIME_W-1:0]     now_q, now_d;
  logic [lnksw_pkg::TIME_W-1:0]     last_q, last_d;
  logic [WINDOW_SLOTS-1:0]          marks_q, marks_d;
  logic [PW-1:0]                    pos_q, pos_d;
  logic [FILL_W-1:0]                fill_q, fill_d;
  logic [lnksw_pkg::TOTAL_W-1:0]    total_q, total_d;
  logic [FILL_W-1:0]                k_q, k_d;
  logic [FILL_W-1:0]                hits_q, hits_d;
  logic [lnksw_pkg::PCT_W-1:0]      pct_q, pct_d;
  logic                             ov_q, ov_d;
  logic [lnksw_pkg::TOTAL_W-1:0]    o_total_q, o_total_d;
  logic [FILL_W-1:0]                o_fill_q, o_fill_d;
  logic [lnksw_pkg::PCT_W-1:0]      o_pct_q, o_pct_d;

  logic [lnksw_pkg::TIME_W-1:0]     diff;
  logic                             open_slot;
  logic [PW-1:0]                    pos_next, pos_prev;
  logic [PRW-1:0]                   prod;
  logic                             div_start;
  lnksw_pkg::div_status_t           div_st;
  logic [lnksw_pkg::PCT_W-1:0]      div_quot;

  assign diff      = now_q - last_q;
  assign open_slot = (act_q == lnksw_pkg::ACT_TIME) && !diff[lnksw_pkg::TIME_W-1] &&
                     (diff[lnksw_pkg::PERIOD_W-1:0] >= period_q);
  assign pos_next  = (pos_q == PW'(WINDOW_SLOTS - 1)) ? '0 : pos_q + 1'b1;
  assign pos_prev  = (pos_q == '0) ? PW'(WINDOW_SLOTS - 1) : pos_q - 1'b1;
  assign prod      = PRW'(hits_q) * PRW'(lnksw_pkg::PERCENT_SCALE);
  assign div_start = (state_q == ST_DIVS);

  lnksw_div #(.FILL_W(FILL_W)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (prod),
    .divisor_i  (fill_q),
    .status_o   (div_st),
    .quot_o     (div_quot)
  );

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = (state_q == ST_IDLE);

  always_comb begin
    state_d   = state_q;
    period_d  = period_q;
    act_d     = act_q;
    now_d     = now_q;
    last_d    = last_q;
    marks_d   = marks_q;
    pos_d     = pos_q;
    fill_d    = fill_q;
    total_d   = total_q;
    k_d       = k_q;
    hits_d    = hits_q;
    pct_d     = pct_q;
    ov_d      = ov_q;
    o_total_d = o_total_q;
    o_fill_d  = o_fill_q;
    o_pct_d   = o_pct_q;

    if (cfg_i.valid) begin
      period_d = cfg_i.slot_period_ms;
    end
    if (ov_q && out_o.ready) begin
      ov_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          act_d   = in_i.action;
          now_d   = in_i.now_ms;
          state_d = ST_UPD;
        end
      end
      ST_UPD: begin
        if (act_q == lnksw_pkg::ACT_TIME) begin
          if (open_slot) begin
            last_d         = now_q;
            marks_d[pos_q] = 1'b0;
            pos_d          = pos_next;
            if (fill_q < FILL_W'(WINDOW_SLOTS)) begin
              fill_d = fill_q + 1'b1;
            end
          end
        end else begin
          if (fill_q != '0) begin
            marks_d[pos_prev] = 1'b1;
          end
          if (total_q != lnksw_pkg::TOTAL_MAX) begin
            total_d = total_q + 1'b1;
          end
        end
        k_d     = '0;
        hits_d  = '0;
        state_d = ST_CNT;
      end
      ST_CNT: begin
        if (k_q == fill_q) begin
          if (fill_q == '0) begin
            pct_d   = '0;
            state_d = ST_DONE;
          end else begin
            state_d = ST_DIVS;
          end
        end else begin
          hits_d = hits_q + FILL_W'(marks_q[k_q[PW-1:0]]);
          k_d    = k_q + 1'b1;
        end
      end
      ST_DIVS: begin
        state_d = ST_DIVW;
      end
      ST_DIVW: begin
        if (div_st.done) begin
          pct_d   = div_quot;
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!ov_q || out_o.ready) begin
          ov_d      = 1'b1;
          o_total_d = total_q;
          o_fill_d  = fill_q;
          o_pct_d   = pct_q;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      period_q <= lnksw_pkg::PERIOD_RESET;
      last_q   <= '0;
      marks_q  <= '0;
      pos_q    <= '0;
      fill_q   <= '0;
      total_q  <= '0;
      ov_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      period_q <= period_d;
      last_q   <= last_d;
      marks_q  <= marks_d;
      pos_q    <= pos_d;
      fill_q   <= fill_d;
      total_q  <= total_d;
      ov_q     <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q     <= act_d;
    now_q     <= now_d;
    k_q       <= k_d;
    hits_q    <= hits_d;
    pct_q     <= pct_d;
    o_total_q <= o_total_d;
    o_fill_q  <= o_fill_d;
    o_pct_q   <= o_pct_d;
  end

  assign out_o.valid           = ov_q;
  assign out_o.total_received  = o_total_q;
  assign out_o.slots_filled    = o_fill_q;
  assign out_o.success_percent = o_pct_q;

  `LNKSW_ASSERT_NOW(a_fill_cap, 1'b1, fill_q <= FILL_W'(WINDOW_SLOTS), "fill count over window")
  `LNKSW_ASSERT_NEXT(a_accept_upd, in_i.valid && in_i.ready, state_q == ST_UPD, "beat not taken")
  `LNKSW_ASSERT_NOW(a_hits_le_k, state_q == ST_CNT, hits_q <= k_q, "hit count ahead of scan")
  `LNKSW_ASSERT_NOW(a_pct_range, div_st.done, div_quot <= PCT_MAX, "percent over scale")
  `LNKSW_ASSERT_NOW(a_div_idle, state_q == ST_IDLE, !div_st.busy, "divider busy in idle")

endmodule
`default_nettype wire
